// ----- hw/rtl/rfbs_pkg.sv -----
package rfbs_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 10;
    localparam int CntW     = 10;
    localparam int PosW     = 7;
    localparam int RunW     = 4;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_PAUSE_BITS     = 3'd0,
        CFG_PREAMBLE_BITS  = 3'd1,
        CFG_DELIMITER_BITS = 3'd2,
        CFG_EPILOGUE_BITS  = 3'd3,
        CFG_ZERO_RUN_LIMIT = 3'd4,
        CFG_ENCODING_MODE  = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_PAUSE    = 3'd0,
        PH_PREAMBLE = 3'd1,
        PH_DELIM    = 3'd2,
        PH_DATA     = 3'd3,
        PH_EPILOGUE = 3'd4
    } t_phase;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } t_op;

    typedef enum logic {
        ENC_STUFF      = 1'b0,
        ENC_MANCHESTER = 1'b1
    } t_enc;

    typedef struct packed {
        logic [9:0] pause_bits;
        logic [7:0] preamble_bits;
        logic [7:0] delimiter_bits;
        logic [7:0] epilogue_bits;
        logic [3:0] zero_run_limit;
        t_enc       encoding_mode;
    } t_cfg;

    typedef struct packed {
        logic line_bit;
        logic busy_res;
        logic load_accepted;
    } t_result;

    localparam logic [9:0] RstPauseBits    = 10'd16;
    localparam logic [7:0] RstPreambleBits = 8'd16;
    localparam logic [7:0] RstDelimBits    = 8'd8;
    localparam logic [7:0] RstEpilogueBits = 8'd4;
    localparam logic [3:0] RstZeroRunLimit = 4'd4;

endpackage

// ----- hw/rtl/rfbs_cfg_regs.sv -----
module rfbs_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rfbs_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  logic [rfbs_pkg::CfgDataW-1:0]      i_cfg_wdata,
    output rfbs_pkg::t_cfg                     o_cfg
);

    rfbs_pkg::t_cfg r_cfg;
    rfbs_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (rfbs_pkg::t_cfg_idx'(i_cfg_idx))
                rfbs_pkg::CFG_PAUSE_BITS:     n_cfg.pause_bits     = i_cfg_wdata[9:0];
                rfbs_pkg::CFG_PREAMBLE_BITS:  n_cfg.preamble_bits  = i_cfg_wdata[7:0];
                rfbs_pkg::CFG_DELIMITER_BITS: n_cfg.delimiter_bits = i_cfg_wdata[7:0];
                rfbs_pkg::CFG_EPILOGUE_BITS:  n_cfg.epilogue_bits  = i_cfg_wdata[7:0];
                rfbs_pkg::CFG_ZERO_RUN_LIMIT: n_cfg.zero_run_limit = i_cfg_wdata[3:0];
                rfbs_pkg::CFG_ENCODING_MODE:
                    n_cfg.encoding_mode = rfbs_pkg::t_enc'(i_cfg_wdata[0]);
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pause_bits     <= rfbs_pkg::RstPauseBits;
            r_cfg.preamble_bits  <= rfbs_pkg::RstPreambleBits;
            r_cfg.delimiter_bits <= rfbs_pkg::RstDelimBits;
            r_cfg.epilogue_bits  <= rfbs_pkg::RstEpilogueBits;
            r_cfg.zero_run_limit <= rfbs_pkg::RstZeroRunLimit;
            r_cfg.encoding_mode  <= rfbs_pkg::ENC_STUFF;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/rfbs_store.sv -----
module rfbs_store #(
    parameter int BUFFER_BYTES = 64,
    parameter int AddrW        = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [7:0]       i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [7:0]       o_rdata
);

    logic [7:0] mem [0:BUFFER_BYTES-1];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/rfbs_framer.sv -----
module rfbs_framer #(
    parameter int BUFFER_BYTES = 64,
    parameter int AddrW        = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic                  i_operation,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last_byte,
    input  rfbs_pkg::t_cfg        i_cfg,
    input  logic [7:0]            i_rd_byte,
    output logic                  o_we,
    output logic [AddrW-1:0]      o_waddr,
    output logic [7:0]            o_wdata,
    output logic [AddrW-1:0]      o_raddr,
    output rfbs_pkg::t_result     o_result
);

    localparam logic [rfbs_pkg::PosW-1:0] BufLen = rfbs_pkg::PosW'(BUFFER_BYTES);

    rfbs_pkg::t_phase                r_phase, n_phase;
    logic [rfbs_pkg::CntW-1:0]       r_bc, n_bc;
    logic [rfbs_pkg::RunW-1:0]       r_zr, n_zr;
    logic                            r_half, n_half;
    logic                            r_line, n_line;
    logic [rfbs_pkg::PosW-1:0]       r_wp, n_wp;
    logic [rfbs_pkg::PosW-1:0]       r_pl, n_pl;
    logic                            r_sending, n_sending;
    logic                            accepted;
    logic                            data_bit;
    logic [rfbs_pkg::CntW-1:0]       data_end;

    assign data_bit = i_rd_byte[r_bc[2:0]];
    assign data_end = {r_pl, 3'b000};

    always_comb begin
        n_phase   = r_phase;
        n_bc      = r_bc;
        n_zr      = r_zr;
        n_half    = r_half;
        n_line    = r_line;
        n_wp      = r_wp;
        n_pl      = r_pl;
        n_sending = r_sending;
        accepted  = 1'b0;
        o_we      = 1'b0;
        if (i_fire && rfbs_pkg::t_op'(i_operation) == rfbs_pkg::OP_LOAD) begin
            if (!r_sending) begin
                accepted = 1'b1;
                if (r_wp < BufLen) begin
                    o_we = 1'b1;
                    n_wp = r_wp + 1'b1;
                end
                if (i_last_byte) begin
                    n_pl      = n_wp;
                    n_wp      = '0;
                    n_sending = 1'b1;
                end
            end
        end else if (i_fire && r_sending) begin
            case (r_phase)
                rfbs_pkg::PH_PREAMBLE: begin
                    n_line = 1'b1;
                    n_bc   = r_bc + 1'b1;
                    if (n_bc >= {2'b00, i_cfg.preamble_bits}) begin
                        n_bc    = '0;
                        n_phase = rfbs_pkg::PH_DELIM;
                    end
                end
                rfbs_pkg::PH_DELIM: begin
                    n_line = r_bc[0];
                    n_bc   = r_bc + 1'b1;
                    if (n_bc >= {2'b00, i_cfg.delimiter_bits}) begin
                        n_bc    = '0;
                        n_phase = rfbs_pkg::PH_DATA;
                    end
                end
                rfbs_pkg::PH_DATA: begin
                    if (i_cfg.encoding_mode == rfbs_pkg::ENC_MANCHESTER) begin
                        n_line = r_half ^ data_bit;
                        n_bc   = r_bc + {{(rfbs_pkg::CntW-1){1'b0}}, r_half};
                        n_half = ~r_half;
                    end else if (data_bit) begin
                        n_zr   = '0;
                        n_line = 1'b1;
                        n_bc   = r_bc + 1'b1;
                    end else if (i_cfg.zero_run_limit != '0 && r_zr == i_cfg.zero_run_limit) begin
                        n_zr   = '0;
                        n_line = 1'b1;
                    end else begin
                        n_zr   = r_zr + 1'b1;
                        n_line = 1'b0;
                        n_bc   = r_bc + 1'b1;
                    end
                    if (n_bc >= data_end) begin
                        n_zr    = '0;
                        n_half  = 1'b0;
                        n_bc    = '0;
                        n_phase = rfbs_pkg::PH_EPILOGUE;
                    end
                end
                rfbs_pkg::PH_EPILOGUE: begin
                    n_bc = r_bc + 1'b1;
                    if (n_bc <= {2'b00, i_cfg.epilogue_bits}) begin
                        n_line = 1'b1;
                    end else begin
                        n_bc      = '0;
                        n_phase   = rfbs_pkg::PH_PAUSE;
                        n_line    = 1'b0;
                        n_pl      = '0;
                        n_sending = 1'b0;
                    end
                end
                default: begin
                    n_phase = rfbs_pkg::PH_PAUSE;
                    n_line  = 1'b0;
                    n_bc    = r_bc + 1'b1;
                    if (n_bc >= i_cfg.pause_bits) begin
                        n_bc = '0;
                        if (r_pl != '0) begin
                            n_phase = rfbs_pkg::PH_PREAMBLE;
                            n_line  = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= rfbs_pkg::PH_PAUSE;
            r_bc      <= '0;
            r_zr      <= '0;
            r_half    <= 1'b0;
            r_line    <= 1'b0;
            r_wp      <= '0;
            r_pl      <= '0;
            r_sending <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_bc      <= n_bc;
            r_zr      <= n_zr;
            r_half    <= n_half;
            r_line    <= n_line;
            r_wp      <= n_wp;
            r_pl      <= n_pl;
            r_sending <= n_sending;
        end
    end

    // The store is addressed with the next bit counter, so its registered read holds the byte of the current bit.
    assign o_raddr = n_bc[3 +: AddrW];
    assign o_waddr = r_wp[AddrW-1:0];
    assign o_wdata = i_data_byte;

    assign o_result.line_bit      = n_line;
    assign o_result.busy_res      = n_sending;
    assign o_result.load_accepted = accepted;

endmodule

// ----- hw/rtl/rfbs_out_skid.sv -----
module rfbs_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rfbs_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output rfbs_pkg::t_result o_data
);

    logic              r_out_valid, n_out_valid;
    logic              r_skid_valid, n_skid_valid;
    rfbs_pkg::t_result r_out, n_out;
    rfbs_pkg::t_result r_skid, n_skid;
    logic              take;

    assign take = r_out_valid && !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = i_data;
                n_out_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ----- hw/rtl/radio_frame_bit_serializer_top.sv -----
// Channel  | Handshake                | Payload
// ---------+--------------------------+------------------------------------------
// input    | i_in_valid / o_in_stall  | i_operation, i_data_byte, i_last_byte
// output   | o_out_valid / i_out_stall| o_line_bit, o_busy_res, o_load_accepted
// config   | i_cfg_we                 | i_cfg_idx, i_cfg_wdata
//
// One transaction is taken every cycle while o_in_stall is low, and its result is registered in the output stage.
// The packet byte that holds the next data bit is read from the store in advance,
// addressed by the next bit counter, so every tick finds its bit ready.
// Reset is synchronous and active low; the store is not cleared.
// A two-entry output stage raises o_in_stall only while it holds a second result.
module radio_frame_bit_serializer_top #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_operation,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_last_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_line_bit,
    output logic                              o_busy_res,
    output logic                              o_load_accepted,
    input  logic                              i_cfg_we,
    input  logic [rfbs_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [rfbs_pkg::CfgDataW-1:0]     i_cfg_wdata
);

    localparam int AddrW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

    rfbs_pkg::t_cfg    cfg;
    rfbs_pkg::t_result result;
    rfbs_pkg::t_result out_data;
    logic              fire;
    logic              full;
    logic              we;
    logic [AddrW-1:0]  waddr;
    logic [AddrW-1:0]  raddr;
    logic [7:0]        wdata;
    logic [7:0]        rd_byte;

    assign fire       = i_in_valid && !full;
    assign o_in_stall = full;

    rfbs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    rfbs_store #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .AddrW        (AddrW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_byte)
    );

    rfbs_framer #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .AddrW        (AddrW)
    ) u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_operation (i_operation),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_cfg       (cfg),
        .i_rd_byte   (rd_byte),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .o_result    (result)
    );

    rfbs_out_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (result),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_data)
    );

    assign o_line_bit      = out_data.line_bit;
    assign o_busy_res      = out_data.busy_res;
    assign o_load_accepted = out_data.load_accepted;

endmodule

// ----- tb/radio_frame_bit_serializer_top_tb.sv -----
module radio_frame_bit_serializer_top_tb;

    localparam int          BufferBytes  = 64;
    localparam int          TbAddrW      = $clog2(BufferBytes);
    localparam int          CycleLimit   = 2_000_000;
    localparam int          MaxTicks     = 100_000;
    localparam int          RandomTarget = 1500;
    localparam logic [rfbs_pkg::CfgIdxW-1:0] CfgIdxSpare0 = 3'd6;
    localparam logic [rfbs_pkg::CfgIdxW-1:0] CfgIdxSpare1 = 3'd7;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic                            i_operation;
    logic [7:0]                      i_data_byte;
    logic                            i_last_byte;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic                            o_line_bit;
    logic                            o_busy_res;
    logic                            o_load_accepted;
    logic                            i_cfg_we;
    logic [rfbs_pkg::CfgIdxW-1:0]    i_cfg_idx;
    logic [rfbs_pkg::CfgDataW-1:0]   i_cfg_wdata;

    // Shadow copy of the serializer state and its registers.
    logic [7:0]                      packet_store [BufferBytes];
    logic [rfbs_pkg::PosW-1:0]       wr_pos     = '0;
    logic [rfbs_pkg::PosW-1:0]       pkt_len    = '0;
    logic                            sending    = 1'b0;
    rfbs_pkg::t_phase                line_phase = rfbs_pkg::PH_PAUSE;
    logic [rfbs_pkg::CntW-1:0]       bit_cnt    = '0;
    logic [rfbs_pkg::RunW-1:0]       zero_run   = '0;
    logic                            man_half   = 1'b0;
    logic                            line_lvl   = 1'b0;
    rfbs_pkg::t_cfg                  cfg_now    = {rfbs_pkg::RstPauseBits,
                                                   rfbs_pkg::RstPreambleBits,
                                                   rfbs_pkg::RstDelimBits,
                                                   rfbs_pkg::RstEpilogueBits,
                                                   rfbs_pkg::RstZeroRunLimit,
                                                   rfbs_pkg::ENC_STUFF};

    rfbs_pkg::t_result               expected_line_results [$];
    logic                            step_counted;
    int unsigned                     effective_items = 0;
    int unsigned                     items_sent      = 0;
    int unsigned                     frames_done     = 0;
    int unsigned                     results_checked = 0;
    int unsigned                     mismatches      = 0;
    int unsigned                     cycle_count     = 0;
    int unsigned                     holdoff_left    = 0;
    bit                              quiet           = 1'b0;

    radio_frame_bit_serializer_top #(
        .BUFFER_BYTES(BufferBytes)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_line_bit      (o_line_bit),
        .o_busy_res      (o_busy_res),
        .o_load_accepted (o_load_accepted),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CycleLimit) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_line_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic rfbs_pkg::t_result predict_line_step(rfbs_pkg::t_op op,
                                                            logic [7:0] data, logic last);
        rfbs_pkg::t_result res;
        logic              cur_bit;
        res = '0;
        step_counted = 1'b0;
        if (op == rfbs_pkg::OP_LOAD) begin
            if (!sending) begin
                res.load_accepted = 1'b1;
                step_counted = 1'b1;
                if (wr_pos < BufferBytes) begin
                    packet_store[wr_pos[TbAddrW-1:0]] = data;
                    wr_pos = wr_pos + 1'b1;
                end
                if (last) begin
                    pkt_len = wr_pos;
                    wr_pos  = '0;
                    sending = 1'b1;
                end
            end
        end else if (sending) begin
            step_counted = 1'b1;
            case (line_phase)
                rfbs_pkg::PH_PREAMBLE: begin
                    line_lvl = 1'b1;
                    bit_cnt  = bit_cnt + 1'b1;
                    if (bit_cnt >= cfg_now.preamble_bits) begin
                        bit_cnt    = '0;
                        line_phase = rfbs_pkg::PH_DELIM;
                    end
                end
                rfbs_pkg::PH_DELIM: begin
                    line_lvl = bit_cnt[0];
                    bit_cnt  = bit_cnt + 1'b1;
                    if (bit_cnt >= cfg_now.delimiter_bits) begin
                        bit_cnt    = '0;
                        line_phase = rfbs_pkg::PH_DATA;
                    end
                end
                rfbs_pkg::PH_DATA: begin
                    cur_bit = packet_store[bit_cnt[3 +: TbAddrW]][bit_cnt[2:0]];
                    if (cfg_now.encoding_mode == rfbs_pkg::ENC_MANCHESTER) begin
                        line_lvl = man_half ^ cur_bit;
                        bit_cnt  = bit_cnt + rfbs_pkg::CntW'(man_half);
                        man_half = ~man_half;
                    end else if (cur_bit) begin
                        zero_run = '0;
                        line_lvl = 1'b1;
                        bit_cnt  = bit_cnt + 1'b1;
                    end else if (cfg_now.zero_run_limit != '0 &&
                                 zero_run == cfg_now.zero_run_limit) begin
                        zero_run = '0;
                        line_lvl = 1'b1;
                    end else begin
                        zero_run = zero_run + 1'b1;
                        line_lvl = 1'b0;
                        bit_cnt  = bit_cnt + 1'b1;
                    end
                    if (bit_cnt >= {pkt_len, 3'b000}) begin
                        zero_run   = '0;
                        man_half   = 1'b0;
                        bit_cnt    = '0;
                        line_phase = rfbs_pkg::PH_EPILOGUE;
                    end
                end
                rfbs_pkg::PH_EPILOGUE: begin
                    bit_cnt = bit_cnt + 1'b1;
                    if (bit_cnt <= cfg_now.epilogue_bits) begin
                        line_lvl = 1'b1;
                    end else begin
                        bit_cnt    = '0;
                        line_phase = rfbs_pkg::PH_PAUSE;
                        line_lvl   = 1'b0;
                        pkt_len    = '0;
                        sending    = 1'b0;
                        frames_done++;
                    end
                end
                default: begin
                    line_phase = rfbs_pkg::PH_PAUSE;
                    line_lvl   = 1'b0;
                    bit_cnt    = bit_cnt + 1'b1;
                    if (bit_cnt >= cfg_now.pause_bits) begin
                        bit_cnt = '0;
                        if (pkt_len != '0) begin
                            line_phase = rfbs_pkg::PH_PREAMBLE;
                            line_lvl   = 1'b1;
                        end
                    end
                end
            endcase
        end
        res.line_bit = line_lvl;
        res.busy_res = sending;
        return res;
    endfunction

    always @(posedge i_clk) begin : result_check
        rfbs_pkg::t_result want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            results_checked++;
            if (expected_line_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result %0d with no transaction waiting: line=%b busy=%b acc=%b",
                             results_checked, o_line_bit, o_busy_res, o_load_accepted);
            end else begin
                want = expected_line_results.pop_front();
                if (o_line_bit !== want.line_bit || o_busy_res !== want.busy_res ||
                    o_load_accepted !== want.load_accepted) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result %0d: expected %b/%b/%b (line/busy/acc), got %b/%b/%b",
                                 results_checked, want.line_bit, want.busy_res,
                                 want.load_accepted, o_line_bit, o_busy_res, o_load_accepted);
                end
            end
        end
    end

    initial begin : out_stall_drive
        int unsigned run_left;
        int unsigned span;
        run_left    = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_left != 0) begin
                i_out_stall <= 1'b1;
                holdoff_left--;
            end else if (run_left != 0) begin
                run_left--;
            end else begin
                span = pick_gap();
                if (span != 0) begin
                    i_out_stall <= 1'b1;
                    run_left = span - 1;
                end else begin
                    i_out_stall <= 1'b0;
                    run_left = $urandom_range(0, 5);
                end
            end
        end
    end

    task automatic send_item(input rfbs_pkg::t_op op, input logic [7:0] data,
                             input logic last);
        int unsigned gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_data_byte <= data;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_line_results.push_back(predict_line_step(op, data, last));
        items_sent++;
        if (step_counted) effective_items++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_line_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rfbs_pkg::CfgIdxW-1:0]  idx,
                             input logic [rfbs_pkg::CfgDataW-1:0] value);
        logic [rfbs_pkg::CfgDataW-1:0] keep;
        logic [rfbs_pkg::CfgDataW-1:0] wdata;
        case (idx)
            rfbs_pkg::CFG_PREAMBLE_BITS, rfbs_pkg::CFG_DELIMITER_BITS,
            rfbs_pkg::CFG_EPILOGUE_BITS:  keep = 10'h0FF;
            rfbs_pkg::CFG_ZERO_RUN_LIMIT: keep = 10'h00F;
            rfbs_pkg::CFG_ENCODING_MODE:  keep = 10'h001;
            default:                      keep = 10'h3FF;
        endcase
        wdata = (value & keep) | (rfbs_pkg::CfgDataW'($urandom) & ~keep);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= wdata;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            rfbs_pkg::CFG_PAUSE_BITS:     cfg_now.pause_bits     = wdata;
            rfbs_pkg::CFG_PREAMBLE_BITS:  cfg_now.preamble_bits  = wdata[7:0];
            rfbs_pkg::CFG_DELIMITER_BITS: cfg_now.delimiter_bits = wdata[7:0];
            rfbs_pkg::CFG_EPILOGUE_BITS:  cfg_now.epilogue_bits  = wdata[7:0];
            rfbs_pkg::CFG_ZERO_RUN_LIMIT: cfg_now.zero_run_limit = wdata[3:0];
            rfbs_pkg::CFG_ENCODING_MODE:  cfg_now.encoding_mode  = rfbs_pkg::t_enc'(wdata[0]);
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [9:0] pause, input logic [7:0] pre,
                                  input logic [7:0] delim, input logic [7:0] epi,
                                  input logic [3:0] zrl, input rfbs_pkg::t_enc enc);
        write_reg(rfbs_pkg::CFG_PAUSE_BITS, pause);
        write_reg(rfbs_pkg::CFG_PREAMBLE_BITS, {2'b00, pre});
        write_reg(rfbs_pkg::CFG_DELIMITER_BITS, {2'b00, delim});
        write_reg(rfbs_pkg::CFG_EPILOGUE_BITS, {2'b00, epi});
        write_reg(rfbs_pkg::CFG_ZERO_RUN_LIMIT, {6'd0, zrl});
        write_reg(rfbs_pkg::CFG_ENCODING_MODE, {9'd0, enc});
    endtask

    task automatic load_packet(input int unsigned n_bytes);
        logic [7:0] b;
        for (int unsigned i = 0; i < n_bytes; i++) begin
            case ($urandom_range(0, 4))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                2:       b = 8'($urandom) & 8'($urandom);
                default: b = 8'($urandom);
            endcase
            send_item(rfbs_pkg::OP_LOAD, b, i == n_bytes - 1);
        end
    endtask

    // Ticks the frame out; the occasional load is offered while busy and must be refused.
    task automatic drain_frame(input int unsigned max_ticks);
        int unsigned n;
        n = 0;
        while (sending && n < max_ticks) begin
            if ($urandom_range(0, 99) < 6) begin
                send_item(rfbs_pkg::OP_LOAD, 8'($urandom), 1'($urandom));
            end else begin
                send_item(rfbs_pkg::OP_TICK, 8'($urandom), 1'($urandom));
                n++;
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_item(rfbs_pkg::OP_TICK, 8'hFF, 1'b1);
        send_item(rfbs_pkg::OP_TICK, 8'h00, 1'b0);
        send_item(rfbs_pkg::OP_LOAD, 8'h00, 1'b1);
        drain_frame(MaxTicks);
    endtask

    task automatic test_special_cases();
        wait_idle();
        apply_settings(10'd0, 8'd0, 8'd0, 8'd0, 4'd4, rfbs_pkg::ENC_STUFF);
        send_item(rfbs_pkg::OP_LOAD, 8'hFF, 1'b0);
        send_item(rfbs_pkg::OP_LOAD, 8'h00, 1'b1);
        send_item(rfbs_pkg::OP_LOAD, 8'h5A, 1'b1);
        drain_frame(MaxTicks);

        wait_idle();
        apply_settings(10'd1, 8'd1, 8'd1, 8'd0, 4'd0, rfbs_pkg::ENC_STUFF);
        send_item(rfbs_pkg::OP_LOAD, 8'h00, 1'b0);
        send_item(rfbs_pkg::OP_LOAD, 8'h00, 1'b1);
        drain_frame(MaxTicks);

        wait_idle();
        apply_settings(10'd1, 8'd2, 8'd3, 8'd1, 4'd1, rfbs_pkg::ENC_STUFF);
        send_item(rfbs_pkg::OP_LOAD, 8'h00, 1'b1);
        drain_frame(MaxTicks);

        wait_idle();
        apply_settings(10'd2, 8'd1, 8'd2, 8'd2, 4'd4, rfbs_pkg::ENC_MANCHESTER);
        send_item(rfbs_pkg::OP_LOAD, 8'hA5, 1'b0);
        send_item(rfbs_pkg::OP_LOAD, 8'h3C, 1'b1);
        drain_frame(MaxTicks);

        // Registers changed while a frame is half sent take effect immediately.
        send_item(rfbs_pkg::OP_LOAD, 8'h0F, 1'b0);
        send_item(rfbs_pkg::OP_LOAD, 8'hF0, 1'b1);
        drain_frame(9);
        wait_idle();
        write_reg(rfbs_pkg::CFG_ENCODING_MODE, {9'd0, rfbs_pkg::ENC_STUFF});
        write_reg(rfbs_pkg::CFG_ZERO_RUN_LIMIT, 10'd2);
        drain_frame(MaxTicks);

        wait_idle();
        write_reg(CfgIdxSpare0, 10'h3FF);
        write_reg(CfgIdxSpare1, 10'h155);
        send_item(rfbs_pkg::OP_LOAD, 8'h81, 1'b1);
        drain_frame(MaxTicks);
    endtask

    task automatic test_full_buffer();
        wait_idle();
        apply_settings(10'd3, 8'd2, 8'd2, 8'd1, 4'd3, rfbs_pkg::ENC_STUFF);
        load_packet(BufferBytes + 6);
        drain_frame(MaxTicks);
    endtask

    task automatic test_extreme_settings();
        wait_idle();
        apply_settings(10'd1023, 8'd255, 8'd255, 8'd255, 4'd15, rfbs_pkg::ENC_STUFF);
        send_item(rfbs_pkg::OP_LOAD, 8'h00, 1'b1);
        drain_frame(MaxTicks);
    endtask

    task automatic test_output_holdoff();
        wait_idle();
        apply_settings(10'd4, 8'd3, 8'd4, 8'd2, 4'd2, rfbs_pkg::ENC_MANCHESTER);
        quiet = 1'b1;
        holdoff_left = 150;
        load_packet(3);
        drain_frame(MaxTicks);
        quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        int unsigned start_count;
        int unsigned round;
        start_count = effective_items;
        round = 0;
        while (effective_items - start_count < RandomTarget) begin
            wait_idle();
            quiet = (round % 5 == 3);
            apply_settings(10'($urandom_range(0, 24)), 8'($urandom_range(0, 20)),
                           8'($urandom_range(0, 12)), 8'($urandom_range(0, 10)),
                           4'($urandom_range(0, 15)),
                           rfbs_pkg::t_enc'($urandom_range(0, 1)));
            repeat (4) begin
                if ($urandom_range(0, 9) < 8) begin
                    if (sending) drain_frame(MaxTicks);
                    load_packet(($urandom_range(0, 29) == 0) ? $urandom_range(60, 70)
                                                             : $urandom_range(1, 6));
                    drain_frame(($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : MaxTicks);
                end else begin
                    repeat ($urandom_range(2, 8))
                        send_item(rfbs_pkg::t_op'($urandom_range(0, 1)), 8'($urandom),
                                  $urandom_range(0, 3) == 0);
                end
            end
            round++;
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_operation = rfbs_pkg::OP_TICK;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_special_cases();
        test_full_buffer();
        test_extreme_settings();
        test_output_holdoff();
        test_random_traffic();
        wait_idle();

        $display("Offered %0d transactions, %0d of which loaded bytes or advanced the line.",
                 items_sent, effective_items);
        $display("%0d frames sent in full, %0d results checked, %0d mismatches.",
                 frames_done, results_checked, mismatches);
        if (mismatches == 0 && expected_line_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
